>>> design/visual_crypto_share_generator_macros.svh
// Assertion macros shared by the share generator design files.
// Define NO_ASSERTIONS to compile them away.
`ifndef VISUAL_CRYPTO_SHARE_GENERATOR_MACROS_SVH
`define VISUAL_CRYPTO_SHARE_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge out of reset.
`define VCS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: label");

// Antecedent in a cycle implies the consequent in the same cycle.
`define VCS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Antecedent in a cycle implies the consequent in the next cycle.
`define VCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define VCS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define VCS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define VCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/vcs_pkg.sv
package vcs_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED    = 1'b1;

    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_DATA_W-1:0] MODULUS_RESET = 32'd1050589;
    localparam logic [CFG_DATA_W-1:0] SEED_RESET    = 32'd1000;

    // Pixel and result layout
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int RESULT_W   = 8;
    localparam logic [CHAN_W-1:0] CHAN_WHITE = 8'd255;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_SETUP,
        ST_SQUARE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic reduce_step;
        logic square_init;
        logic sel_q;
        logic square_step;
        logic write_back;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_reduce;
        logic count_last;
        logic out_free;
    } status_t;

endpackage

>>> design/vcs_ctrl.sv
module vcs_ctrl
    import vcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.need_reduce ? ST_REDUCE : ST_SQUARE;
            end
            ST_REDUCE:
            begin
                if (status.count_last)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                if (status.count_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command decode
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK:
            begin
                // Operand already below the modulus, or a zero modulus: square it straight away.
                cmd.square_init = !status.need_reduce;
                cmd.sel_q       = 1'b1;
            end
            ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
            end
            ST_SETUP:
            begin
                cmd.square_init = 1'b1;
            end
            ST_SQUARE:
            begin
                cmd.square_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.write_back = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/vcs_dp.sv
module vcs_dp
    import vcs_pkg::*;
#(
    parameter int MODULUS_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [PIXEL_W-1:0]      pixel,
    input  logic [MODULUS_BITS-1:0] modulus,
    input  logic [MODULUS_BITS-1:0] seed,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [RESULT_W-1:0]     out_data
);

    localparam int W     = MODULUS_BITS;
    localparam int CNT_W = $clog2(MODULUS_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MODULUS_BITS - 1);

    logic [W-1:0]        x_reg, x_next;
    logic                seeded_reg, seeded_next;
    logic [W-1:0]        n_reg, n_next;
    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        q_reg, q_next;
    logic [W-1:0]        r_reg, r_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                key_reg, key_next;
    logic                white_reg, white_next;
    logic                out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0] out_data_reg, out_data_next;

    logic [W-1:0]   x_src;
    logic           white;
    logic           n_zero;
    logic [W:0]     rd_cat;
    logic [W+1:0]   rd_diff;
    logic [W+1:0]   sq_sum;
    logic [W+2:0]   sq_d1;
    logic [W+2:0]   sq_d2;
    logic [W-1:0]   sq_res;
    logic [W-1:0]   sq_op;
    logic           share2_left;

    // Generator value for this pixel: the seed on the first pixel after reset
    assign x_src  = seeded_reg ? x_reg : seed;
    assign white  = (pixel[CHAN_W-1:0] == CHAN_WHITE)
                 && (pixel[2*CHAN_W-1:CHAN_W] == CHAN_WHITE)
                 && (pixel[3*CHAN_W-1:2*CHAN_W] == CHAN_WHITE);
    assign n_zero = (n_reg == '0);

    // One restoring division step: shift in the next dividend bit.
    assign rd_cat  = {a_reg, q_reg[W-1]};
    assign rd_diff = {1'b0, rd_cat} - {2'b00, n_reg};

    // One shift-add squaring step; the sum stays below three times the modulus.
    assign sq_op  = q_reg[W-1] ? a_reg : '0;
    assign sq_sum = {1'b0, r_reg, 1'b0} + {2'b00, sq_op};
    assign sq_d1  = {1'b0, sq_sum} - {3'b000, n_reg};
    assign sq_d2  = {1'b0, sq_sum} - {2'b00, n_reg, 1'b0};

    always_comb
    begin
        if (n_zero)
        begin
            sq_res = sq_sum[W-1:0];
        end
        else if (!sq_d2[W+2])
        begin
            sq_res = sq_d2[W-1:0];
        end
        else if (!sq_d1[W+2])
        begin
            sq_res = sq_d1[W-1:0];
        end
        else
        begin
            sq_res = sq_sum[W-1:0];
        end
    end

    // Register updates under command
    always_comb
    begin
        x_next         = x_reg;
        seeded_next    = seeded_reg;
        n_next         = n_reg;
        a_next         = a_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        white_next     = white_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (cmd.load)
        begin
            seeded_next = 1'b1;
            n_next      = modulus;
            q_next      = x_src;
            a_next      = '0;
            cnt_next    = '0;
            key_next    = x_src[0];
            white_next  = white;
        end

        if (cmd.reduce_step)
        begin
            a_next   = rd_diff[W+1] ? rd_cat[W-1:0] : rd_diff[W-1:0];
            q_next   = {q_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.square_init)
        begin
            a_next   = cmd.sel_q ? q_reg : a_reg;
            q_next   = cmd.sel_q ? q_reg : a_reg;
            r_next   = '0;
            cnt_next = '0;
        end

        if (cmd.square_step)
        begin
            r_next   = sq_res;
            q_next   = {q_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.write_back)
        begin
            x_next         = r_reg;
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, ~share2_left, share2_left,
                              ~key_reg, key_reg, key_reg};
        end
    end

    assign share2_left = white_reg ? key_reg : ~key_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        n_reg        <= n_next;
        a_reg        <= a_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        key_reg      <= key_next;
        white_reg    <= white_next;
        out_data_reg <= out_data_next;
    end

    assign status.need_reduce = !n_zero && (q_reg >= n_reg);
    assign status.count_last  = (cnt_reg == CNT_LAST);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/visual_crypto_share_generator.sv
// Channel   Direction  Contents
// s_axis    in         one secret pixel: blue, green, red
// m_axis    out        key bit and the four share subpixels
// cfg       in         register writes: modulus, seed
//
// A pixel is loaded, reduced by restoring division only when the generator
// value is not below a nonzero modulus, then squared by the shift-add
// squaring unit, one multiplier bit per cycle, and its result written out.
// One pixel is in work at a time; a finished result waits in the output
// register while the next pixel is taken. Reset clears the sequencer, the
// seeded flag and the output valid; the seed is loaded on the first pixel.
`include "visual_crypto_share_generator_macros.svh"

module visual_crypto_share_generator
    import vcs_pkg::*;
#(
    parameter int MODULUS_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // blue [7:0], green [15:8], red [23:16]
    input  logic [PIXEL_W-1:0]     s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // key_bit [0], share1_left [1], share1_right [2], share2_left [3],
    // share2_right [4], zero [7:5]
    output logic [RESULT_W-1:0]    m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CFG_DATA_W-1:0] modulus_reg, modulus_next;
    logic [CFG_DATA_W-1:0] seed_reg, seed_next;
    cmd_t                  cmd;
    status_t               status;

    // Configuration register writes
    always_comb
    begin
        modulus_next = modulus_reg;
        seed_next    = seed_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS: modulus_next = cfg_data;
                REG_SEED:    seed_next    = cfg_data;
                default:     modulus_next = modulus_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            seed_reg    <= SEED_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
            seed_reg    <= seed_next;
        end
    end

    // Sequencer
    vcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Generator, modular squaring and share logic
    vcs_dp #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pixel     (s_axis_tdata),
        .modulus   (MODULUS_BITS'(modulus_reg)),
        .seed      (MODULUS_BITS'(seed_reg)),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    // A request is followed by the work on it, never by a second request.
    `VCS_ASSERT_NEXT(a_one_in_work, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A result is written only into a free output register.
    `VCS_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.write_back, status.out_free)
    // The datapath does at most one kind of work in a cycle.
    `VCS_ASSERT_ALWAYS(a_one_cmd, clk, rst_n, $onehot0({cmd.load, cmd.reduce_step, cmd.square_step, cmd.write_back}))

endmodule

>>> tb/tb_visual_crypto_share_generator.sv
`timescale 1ns / 1ps

module tb_visual_crypto_share_generator;
    import vcs_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DIRECTED_N    = 16;
    localparam int PHASE_N       = 12;
    localparam int BREAK_PERCENT = 34;

    // Pixel as it travels on s_axis_tdata: blue in the lowest byte.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // Result as it travels on m_axis_tdata: key bit in bit 0.
    typedef struct packed {
        logic [RESULT_W-6:0] pad;
        logic                share2_right;
        logic                share2_left;
        logic                share1_right;
        logic                share1_left;
        logic                key_bit;
    } share_t;

    typedef struct {
        pixel_t px;
        bit     typed;
        share_t shares;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIXEL_W-1:0]     s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [RESULT_W-1:0]    m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Own copy of the configuration and the generator state.
    logic [CFG_DATA_W-1:0]  model_modulus = MODULUS_RESET;
    logic [CFG_DATA_W-1:0]  model_seed = SEED_RESET;
    logic [CFG_DATA_W-1:0]  bbs_value = '0;
    bit                     bbs_seeded = 1'b0;

    share_t                 expected_shares[$];
    directed_row_t          directed_rows[DIRECTED_N];
    int unsigned            mismatches = 0;
    int unsigned            cycle_count = 0;
    bit                     calm = 1'b0;

    visual_crypto_share_generator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Squaring of the generator value, exact in 64 bits; a zero modulus wraps at 2^32.
    function automatic logic [CFG_DATA_W-1:0] next_bbs_value(input logic [CFG_DATA_W-1:0] x,
                                                             input logic [CFG_DATA_W-1:0] n);
        logic [63:0] wide;
        if (n == '0)
        begin
            wide = {32'd0, x} * {32'd0, x};
            return wide[CFG_DATA_W-1:0];
        end
        wide = {32'd0, x} % {32'd0, n};
        wide = wide * wide;
        wide = wide % {32'd0, n};
        return wide[CFG_DATA_W-1:0];
    endfunction

    // Draws the key bit for one pixel and works out the four subpixels.
    function automatic share_t predict_shares(input pixel_t px);
        share_t s;
        logic   white;
        if (!bbs_seeded)
        begin
            bbs_value  = model_seed;
            bbs_seeded = 1'b1;
        end
        s         = '0;
        s.key_bit = bbs_value[0];
        bbs_value = next_bbs_value(bbs_value, model_modulus);
        white = (px.blue == CHAN_WHITE) && (px.green == CHAN_WHITE) && (px.red == CHAN_WHITE);
        s.share1_left  = s.key_bit;
        s.share1_right = ~s.key_bit;
        s.share2_left  = white ? s.key_bit : ~s.key_bit;
        s.share2_right = ~s.share2_left;
        return s;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < BREAK_PERCENT);
    endfunction

    // Half white and near-white pixels, the other half fully random.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0, 1, 2: px = {3{CHAN_WHITE}};
            3, 4:
            begin
                px = {3{CHAN_WHITE}};
                case ($urandom_range(2))
                    0: px.blue  = CHAN_W'($urandom_range(254));
                    1: px.green = CHAN_W'($urandom_range(254));
                    default: px.red = CHAN_W'($urandom_range(254));
                endcase
            end
            default: px = r[PIXEL_W-1:0];
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input logic [RESULT_W-1:0] got,
                                   input logic [RESULT_W-1:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_MODULUS: model_modulus = value;
            REG_SEED:    model_seed = value;
            default: ;
        endcase
    endtask

    // Offers one pixel request, with random gaps before it, and records the expectation on accept.
    task automatic offer_pixel(input pixel_t px, input bit typed, input share_t typed_shares);
        share_t predicted;
        @(negedge clk);
        while (take_break())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_shares(px);
        if (typed)
            predicted = typed_shares;
        expected_shares = {expected_shares, predicted};
    endtask

    // Stops sending and waits until every outstanding result has arrived.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_shares.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result side back-pressure.
    always @(negedge clk)
    begin
        m_axis_tready <= !take_break();
    end

    // Each accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        share_t got;
        share_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_shares.size() == 0)
                report_mismatch("result with no request pending", got, '0);
            else
            begin
                want = expected_shares.pop_front();
                if (got.key_bit !== want.key_bit)
                    report_mismatch("key_bit", got, want);
                if (got.share1_left !== want.share1_left)
                    report_mismatch("share1_left", got, want);
                if (got.share1_right !== want.share1_right)
                    report_mismatch("share1_right", got, want);
                if (got.share2_left !== want.share2_left)
                    report_mismatch("share2_left", got, want);
                if (got.share2_right !== want.share2_right)
                    report_mismatch("share2_right", got, want);
                if (got.pad !== want.pad)
                    report_mismatch("padding bits", got, want);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence: reset, directed pixels, then random phases over several moduli.
    initial
    begin
        logic [CFG_DATA_W-1:0] new_modulus;
        logic [CFG_DATA_W-1:0] new_seed;
        int                    phase_items;

        // Only the first row is typed in: seed is all ones, so its key bit is one.
        directed_rows = '{
            '{24'hFFFFFF, 1'b1, 8'b0000_1011},
            '{24'h000000, 1'b0, 8'h00},
            '{24'hFFFFFE, 1'b0, 8'h00},
            '{24'hFFFEFF, 1'b0, 8'h00},
            '{24'hFEFFFF, 1'b0, 8'h00},
            '{24'hFFFFFF, 1'b0, 8'h00},
            '{24'h0000FF, 1'b0, 8'h00},
            '{24'h00FF00, 1'b0, 8'h00},
            '{24'hFF0000, 1'b0, 8'h00},
            '{24'hFFFFFF, 1'b0, 8'h00},
            '{24'hAA55AA, 1'b0, 8'h00},
            '{24'h55AA55, 1'b0, 8'h00},
            '{24'h7F7F7F, 1'b0, 8'h00},
            '{24'h808080, 1'b0, 8'h00},
            '{24'hFFFFFF, 1'b0, 8'h00},
            '{24'h010101, 1'b0, 8'h00}
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Seed above the reset modulus, taken up by the first pixel.
        write_register(REG_SEED, 32'hFFFF_FFFF);
        for (int i = 0; i < DIRECTED_N; i++)
            offer_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].shares);
        drain_results();

        // Degenerate moduli come last, since they trap the generator at zero or one.
        for (int phase = 0; phase < PHASE_N; phase++)
        begin
            calm        = (phase == 1);
            phase_items = 135;
            new_seed    = $urandom;
            case (phase)
                1: new_modulus = $urandom | 32'h8000_0000;
                2: new_modulus = 32'hFFFF_FFFF;
                4: new_modulus = $urandom_range(32'h0000_FFFF, 5);
                5: new_modulus = $urandom | 32'hC000_0000;
                6: new_modulus = $urandom_range(32'h000F_FFFF, 32'h0008_0000);
                8: new_modulus = MODULUS_RESET;
                9:
                begin
                    new_modulus = '0;
                    phase_items = 80;
                end
                10:
                begin
                    new_modulus = 32'd3;
                    new_seed    = 32'hFFFF_FFFF;
                    phase_items = 40;
                end
                11:
                begin
                    new_modulus = 32'd1;
                    new_seed    = '0;
                    phase_items = 40;
                end
                default: new_modulus = $urandom_range(32'hFFFF_FFFF, 5);
            endcase
            if (phase != 0)
            begin
                write_register(REG_MODULUS, new_modulus);
                write_register(REG_SEED, new_seed);
            end
            repeat (phase_items) offer_pixel(random_pixel(), 1'b0, '0);
            drain_results();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
